FILE: design/xoroshiro_random_unit_defines.svh
// Assertion macros for the random unit.
`ifndef XOROSHIRO_RANDOM_UNIT_DEFINES_SVH
`define XOROSHIRO_RANDOM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define XRU_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("xru: implication check failed");

`define XRU_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("xru: next-cycle check failed");

`else

`define XRU_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define XRU_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

FILE: design/xru_pkg.sv
package xru_pkg;

  localparam logic [1:0] ACT_RAW    = 2'd0;
  localparam logic [1:0] ACT_RANGE  = 2'd1;
  localparam logic [1:0] ACT_FRAC   = 2'd2;
  localparam logic [1:0] ACT_RESEED = 2'd3;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic        [63:0] seed_value;
  } xru_in_t;

  typedef struct packed {
    logic        [63:0] raw_value;
    logic signed [31:0] int_value;
    logic        [22:0] unit_fraction;
    logic        [63:0] prev_seed;
    logic               range_error;
  } xru_out_t;

  typedef struct packed {
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] sum;
  } xru_draw_t;

  // One xoroshiro128+ step: next state words and the output.
  function automatic xru_draw_t xru_draw(input logic [63:0] a, input logic [63:0] b);
    xru_draw_t   r;
    logic [63:0] bx;
    bx    = a ^ b;
    r.sum = a + b;
    r.s0  = {a[8:0], a[63:9]} ^ bx ^ {bx[49:0], 14'b0};
    r.s1  = {bx[27:0], bx[63:28]};
    return r;
  endfunction

endpackage

FILE: design/xoroshiro_random_unit.sv
// xoroshiro_random_unit: xoroshiro128+ generator with a splitmix64 seed counter.
// Input channel in_valid/in_stall/in_data carries a request (action, range
// bounds, seed). Output channel out_valid/out_stall/out_data returns exactly
// one result per request; fields not belonging to the action read zero.
// A request transfers when valid is high and stall is low; in_stall is high
// whenever a request is in progress, so one request is worked at a time.
// Work per request: raw, unit fraction and inverted range load the result
// straight from idle; integer range takes the first draw through the
// bit-serial 64x33 multiplier and each redraw through it again, plus the
// threshold remainder, worked out once on the shift-subtract divider when the
// low product falls below the span; reseed runs 4 splitmix multiplies and
// two load steps. The next request is taken in the cycle after the result
// register loads. The multiplier, shared by range and reseed, and the divider
// work one bit a cycle.
// After reset the unit runs a reseed with zero with in_stall high and no
// result produced.
// A finished result sits in the output register while out_stall is high; a
// new request is accepted meanwhile, and its result waits until the register
// frees up.
`include "xoroshiro_random_unit_defines.svh"

module xoroshiro_random_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  xru_pkg::xru_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output xru_pkg::xru_out_t out_data
);
  import xru_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MIX_LOAD, S_MIX_MUL, S_RNG_MUL, S_RNG_DIV, S_DONE
  } state_t;

  state_t      state_r;
  logic [63:0] s0_r, s1_r, ctr_r;
  logic        mix_idx_r, mix_ph_r, init_r;
  // shared shift-add multiplier
  logic [96:0] prod_r;
  logic [63:0] mcand_r, mplier_r;
  logic [5:0]  cnt_r;
  // shift-subtract divider for the rejection threshold
  logic [63:0] dvd_r;
  logic [32:0] rem_r;
  logic [32:0] span_r, thr_r;
  logic        thr_valid_r;
  logic [63:0] lo_r;
  logic [31:0] hi_r;
  logic signed [31:0] low_r;
  xru_out_t    res_r;
  xru_out_t    out_r;
  logic        out_valid_r;

  logic [96:0] prod_nxt;
  logic [33:0] div_cat;
  logic [33:0] div_sub;
  logic [32:0] rem_nxt;
  logic [32:0] span_nxt;
  logic [63:0] mix_p;
  xru_draw_t   dr;
  logic        in_xfer, out_xfer;

  assign prod_nxt = {prod_r[95:0], 1'b0} + (mplier_r[63] ? {33'b0, mcand_r} : 97'b0);
  assign div_cat  = {rem_r, dvd_r[63]};
  assign div_sub  = div_cat - {1'b0, span_r};
  assign rem_nxt  = div_sub[33] ? div_cat[32:0] : div_sub[32:0];
  assign span_nxt = 33'($signed({in_data.range_high[31], in_data.range_high})
                    - $signed({in_data.range_low[31], in_data.range_low}) + 34'sd1);
  assign mix_p    = prod_nxt[63:0];
  assign dr       = xru_draw(s0_r, s1_r);

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_MIX_LOAD;
      ctr_r       <= '0;
      mix_idx_r   <= 1'b0;
      mix_ph_r    <= 1'b0;
      init_r      <= 1'b1;
      thr_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            res_r       <= '0;
            low_r       <= in_data.range_low;
            thr_valid_r <= 1'b0;
            unique case (in_data.action)
              ACT_RAW: begin
                s0_r            <= dr.s0;
                s1_r            <= dr.s1;
                res_r.raw_value <= dr.sum;
                state_r         <= S_DONE;
              end
              ACT_FRAC: begin
                s0_r                <= dr.s0;
                s1_r                <= dr.s1;
                res_r.unit_fraction <= dr.sum[63:41];
                state_r             <= S_DONE;
              end
              ACT_RANGE: begin
                if (in_data.range_high < in_data.range_low) begin
                  res_r.range_error <= 1'b1;
                  state_r           <= S_DONE;
                end else begin
                  span_r   <= span_nxt;
                  s0_r     <= dr.s0;
                  s1_r     <= dr.s1;
                  mcand_r  <= dr.sum;
                  mplier_r <= {span_nxt, 31'b0};
                  prod_r   <= '0;
                  cnt_r    <= 6'd32;
                  state_r  <= S_RNG_MUL;
                end
              end
              ACT_RESEED: begin
                res_r.prev_seed <= ctr_r;
                ctr_r           <= in_data.seed_value;
                mix_idx_r       <= 1'b0;
                state_r         <= S_MIX_LOAD;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_MIX_LOAD: begin
          ctr_r    <= ctr_r + GOLDEN_STEP;
          mcand_r  <= (ctr_r + GOLDEN_STEP) ^ ((ctr_r + GOLDEN_STEP) >> 30);
          mplier_r <= MIX_MUL_A;
          prod_r   <= '0;
          cnt_r    <= 6'd63;
          mix_ph_r <= 1'b0;
          state_r  <= S_MIX_MUL;
        end
        S_MIX_MUL: begin
          prod_r   <= prod_nxt;
          mplier_r <= {mplier_r[62:0], 1'b0};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            if (!mix_ph_r) begin
              mcand_r  <= mix_p ^ (mix_p >> 27);
              mplier_r <= MIX_MUL_B;
              prod_r   <= '0;
              cnt_r    <= 6'd63;
              mix_ph_r <= 1'b1;
            end else if (!mix_idx_r) begin
              s0_r      <= mix_p ^ (mix_p >> 31);
              mix_idx_r <= 1'b1;
              state_r   <= S_MIX_LOAD;
            end else begin
              s1_r    <= mix_p ^ (mix_p >> 31);
              init_r  <= 1'b0;
              state_r <= init_r ? S_IDLE : S_DONE;
            end
          end
        end
        S_RNG_MUL: begin
          prod_r   <= prod_nxt;
          mplier_r <= {mplier_r[62:0], 1'b0};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            lo_r <= prod_nxt[63:0];
            hi_r <= prod_nxt[95:64];
            if (!thr_valid_r && (prod_nxt[63:0] < {31'b0, span_r})) begin
              dvd_r   <= 64'd0 - {31'b0, span_r};
              rem_r   <= '0;
              cnt_r   <= 6'd63;
              state_r <= S_RNG_DIV;
            end else if (thr_valid_r && (prod_nxt[63:0] < {31'b0, thr_r})) begin
              s0_r     <= dr.s0;
              s1_r     <= dr.s1;
              mcand_r  <= dr.sum;
              mplier_r <= {span_r, 31'b0};
              prod_r   <= '0;
              cnt_r    <= 6'd32;
            end else begin
              res_r.int_value <= low_r + $signed(prod_nxt[95:64]);
              state_r         <= S_DONE;
            end
          end
        end
        S_RNG_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[62:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            thr_r       <= rem_nxt;
            thr_valid_r <= 1'b1;
            if (lo_r < {31'b0, rem_nxt}) begin
              // rejected: redraw
              s0_r     <= dr.s0;
              s1_r     <= dr.s1;
              mcand_r  <= dr.sum;
              mplier_r <= {span_r, 31'b0};
              prod_r   <= '0;
              cnt_r    <= 6'd32;
              state_r  <= S_RNG_MUL;
            end else begin
              res_r.int_value <= low_r + $signed(hi_r);
              state_r         <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `XRU_ASSERT_IMP(a_err_clean, clk, rst_n, out_valid_r && out_r.range_error,
                  out_r.raw_value == 64'd0 && out_r.int_value == 32'sd0 &&
                  out_r.prev_seed == 64'd0 && out_r.unit_fraction == 23'd0)
  `XRU_ASSERT_IMP(a_rem_bound, clk, rst_n, state_r == S_RNG_DIV, rem_r < span_r)
  `XRU_ASSERT_IMP(a_thr_bound, clk, rst_n,
                  thr_valid_r && (state_r == S_RNG_MUL || state_r == S_RNG_DIV),
                  thr_r < span_r)
  `XRU_ASSERT_NXT(a_out_drain, clk, rst_n, out_xfer && state_r != S_DONE, !out_valid_r)
  `XRU_ASSERT_IMP(a_stall_busy, clk, rst_n, init_r, state_r != S_IDLE && state_r != S_DONE)

endmodule
